[hw/rtl/rtmp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmp_pkg
// Shared types and constants of the rational tone map pixel pipeline.
// ----------------------------------------------------------------------------
package rtmp_pkg;

   // field widths
   localparam int CHAN_W    = 32;
   localparam int OUT_BITS  = 16;
   localparam int GAIN_W    = 16;
   localparam int LMAX_W    = 32;
   localparam int SHAPE_W   = 13;
   localparam int GAMMA_W   = 16;
   localparam int NUM_LANES = 3;

   // configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPOSURE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LUM  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA    = 8'd3;

   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd256;
   localparam logic [LMAX_W-1:0]  LMAX_RESET  = 32'd65536;
   localparam logic [SHAPE_W-1:0] SHAPE_RESET = 13'd512;
   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd9011;
   localparam logic [SHAPE_W-1:0] SHAPE_ONE   = 13'd256;

   // luminance weights, Q0.16
   localparam logic [15:0] W_RED   = 16'd13938;
   localparam logic [15:0] W_GREEN = 16'd46869;
   localparam logic [15:0] W_BLUE  = 16'd4730;

   // internal widths
   localparam int PROD_W    = 48;
   localparam int SUM_W     = 49;
   localparam int LUM_W     = 33;
   localparam int PD_W      = 46;
   localparam int N_W       = 45;
   localparam int D_W       = 47;
   localparam int LOG_FRAC  = 20;
   localparam int LOG_INT_W = 6;
   localparam int LOG_W     = LOG_INT_W + LOG_FRAC;
   localparam int LOG_LAT   = LOG_FRAC + 3;
   localparam int DVD_W     = LOG_W + 12 + 1;
   localparam int TGT_W     = DVD_W + 2;
   localparam int V_W       = OUT_BITS + 1;

   localparam logic [TGT_W-1:0] TGT_BASE = TGT_W'(OUT_BITS + 1) << LOG_FRAC;
   localparam logic [OUT_BITS-1:0] FULL_SCALE = {OUT_BITS{1'b1}};

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] red_out;
      logic [OUT_BITS-1:0] green_out;
      logic [OUT_BITS-1:0] blue_out;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic lum_zero;
      logic den_zero;
   } lane_ctl_type;

   typedef struct packed {
      lane_ctl_type ctl;
      logic         chan_zero;
      logic         force_full;
   } div_side_type;

   typedef struct packed {
      logic [V_W-1:0]   v;
      logic [V_W-1:0]   cand;
      logic             range_ok;
      logic [TGT_W-1:0] target;
      lane_ctl_type     ctl;
      logic             chan_zero;
      logic             force_full;
   } srch_side_type;

endpackage

[hw/rtl/rtmp_log2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmp_log2
// Pipelined base-2 logarithm in Q.20: leading one search, normalize to Q1.31,
// then one squaring stage per fraction bit. Carries a sideband alongside.
// ----------------------------------------------------------------------------
module rtmp_log2 #(
   parameter int XW = 47,
   parameter int SW = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [XW-1:0]              x_in,
   input  logic [SW-1:0]              side_in,
   output logic [rtmp_pkg::LOG_W-1:0] log_out,
   output logic [SW-1:0]              side_out
);
   localparam int MW  = $clog2(XW);
   localparam int NF  = rtmp_pkg::LOG_FRAC;
   localparam int LAT = rtmp_pkg::LOG_LAT;

   logic [XW-1:0]    x_ff;
   logic [XW-1:0]    xn_ff;
   logic [MW-1:0]    lz_in;
   logic [MW-1:0]    lz_ff;
   logic             zero_ff;
   logic [XW+31:0]   xe;
   logic [XW+31:0]   xs;
   logic [31:0]      z_ff [0:NF];
   logic [NF-1:0]    f_ff [0:NF];
   logic [MW-1:0]    m_ff [0:NF];
   logic             nz_ff [0:NF];
   logic [32:0]      t_in [1:NF];
   logic [SW-1:0]    side_ff [0:LAT-1];

   // leading one position
   always_comb begin
      lz_in = '0;
      for (int i = 0; i < XW; i++) begin
         if (x_ff[i]) begin
            lz_in = MW'(i);
         end
      end
   end

   // normalize to q1.31 by truncation
   always_comb begin
      xe = {32'b0, xn_ff};
      if (32'(lz_ff) >= 32'd31) begin
         xs = xe >> (32'(lz_ff) - 32'd31);
      end else begin
         xs = xe << (32'd31 - 32'(lz_ff));
      end
   end

   // one squaring per fraction bit
   always_comb begin
      for (int k = 1; k <= NF; k++) begin
         t_in[k] = 33'(({32'b0, z_ff[k-1]} * {32'b0, z_ff[k-1]}) >> 31);
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      xn_ff   <= x_ff;
      lz_ff   <= lz_in;
      zero_ff <= (x_ff == '0);
      z_ff[0]  <= xs[31:0];
      f_ff[0]  <= '0;
      m_ff[0]  <= lz_ff;
      nz_ff[0] <= zero_ff;
      for (int k = 1; k <= NF; k++) begin
         z_ff[k]  <= t_in[k][32] ? t_in[k][32:1] : t_in[k][31:0];
         f_ff[k]  <= {f_ff[k-1][NF-2:0], t_in[k][32]};
         m_ff[k]  <= m_ff[k-1];
         nz_ff[k] <= nz_ff[k-1];
      end
   end

   // sideband delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            side_ff[i] <= '0;
         end
      end else begin
         side_ff[0] <= side_in;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign log_out  = nz_ff[NF] ? '0 : {rtmp_pkg::LOG_INT_W'(m_ff[NF]), f_ff[NF]};
   assign side_out = side_ff[LAT-1];

endmodule

[hw/rtl/rtmp_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtmp_lane
// One color channel: log of the numerator, gamma division, and a pipelined
// bit-by-bit search for the rounded power over a chain of log units.
// ----------------------------------------------------------------------------
module rtmp_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rtmp_pkg::N_W-1:0]            n_in,
   input  logic [rtmp_pkg::LOG_W-1:0]          ld_in,
   input  rtmp_pkg::lane_ctl_type              ctl_in,
   input  logic [rtmp_pkg::GAMMA_W-1:0]        gamma_in,
   output logic [rtmp_pkg::OUT_BITS-1:0]       res_out,
   output rtmp_pkg::lane_ctl_type              ctl_out
);
   localparam int DVD_W = rtmp_pkg::DVD_W;
   localparam int V_W   = rtmp_pkg::V_W;
   localparam int GW    = rtmp_pkg::GAMMA_W;
   localparam int TGT_W = rtmp_pkg::TGT_W;
   localparam int LOG_W = rtmp_pkg::LOG_W;
   localparam int OB    = rtmp_pkg::OUT_BITS;

   logic [LOG_W-1:0]       ln;
   logic [0:0]             nz_side;
   logic                   force_w;
   logic [LOG_W-1:0]       att_w;

   logic [GW-1:0]          rem_ff [0:DVD_W];
   logic [DVD_W-1:0]       dvd_ff [0:DVD_W];
   logic [DVD_W-1:0]       quo_ff [0:DVD_W];
   rtmp_pkg::div_side_type dsd_ff [0:DVD_W];
   logic [GW:0]            r2_w   [0:DVD_W-1];
   logic                   sub_w  [0:DVD_W-1];

   rtmp_pkg::srch_side_type tgt_ff;
   rtmp_pkg::srch_side_type st_in  [0:V_W-1];
   rtmp_pkg::srch_side_type st_out [0:V_W-1];
   logic [LOG_W-1:0]        lx     [0:V_W-1];
   logic [V_W-1:0]          x_w    [0:V_W-1];
   logic [V_W-1:0]          v_dec  [0:V_W-1];
   logic [V_W:0]            x2_w   [0:V_W-1];

   logic [OB-1:0]           res_ff;
   rtmp_pkg::lane_ctl_type  ctl_ff;

   // log of the numerator
   rtmp_log2 #(
      .XW (rtmp_pkg::N_W),
      .SW (1)
   ) u_log_n (
      .clock    (clock),
      .reset    (reset),
      .x_in     (n_in),
      .side_in  (n_in == '0),
      .log_out  (ln),
      .side_out (nz_side)
   );

   // attenuation and early saturation
   assign force_w = ctl_in.den_zero || (ln >= ld_in);
   assign att_w   = ld_in - ln;

   // restoring divider, one quotient bit per stage
   always_comb begin
      for (int i = 0; i < DVD_W; i++) begin
         r2_w[i]  = {rem_ff[i], dvd_ff[i][DVD_W-1]};
         sub_w[i] = r2_w[i] >= {1'b0, gamma_in};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      dvd_ff[0] <= {1'b0, att_w, 12'b0} + DVD_W'(gamma_in >> 1);
      quo_ff[0] <= '0;
      for (int i = 0; i < DVD_W; i++) begin
         rem_ff[i+1] <= sub_w[i] ? GW'(r2_w[i] - {1'b0, gamma_in}) : r2_w[i][GW-1:0];
         dvd_ff[i+1] <= {dvd_ff[i][DVD_W-2:0], 1'b0};
         quo_ff[i+1] <= {quo_ff[i][DVD_W-2:0], sub_w[i]};
      end
   end

   // divider sideband
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DVD_W; i++) begin
            dsd_ff[i] <= '0;
         end
         tgt_ff <= '0;
      end else begin
         dsd_ff[0].ctl        <= ctl_in;
         dsd_ff[0].chan_zero  <= nz_side[0];
         dsd_ff[0].force_full <= force_w;
         for (int i = 0; i < DVD_W; i++) begin
            dsd_ff[i+1] <= dsd_ff[i];
         end
         // search target
         tgt_ff.v          <= '0;
         tgt_ff.cand       <= '0;
         tgt_ff.range_ok   <= 1'b0;
         tgt_ff.target     <= rtmp_pkg::TGT_BASE - {2'b0, quo_ff[DVD_W]};
         tgt_ff.ctl        <= dsd_ff[DVD_W].ctl;
         tgt_ff.chan_zero  <= dsd_ff[DVD_W].chan_zero;
         tgt_ff.force_full <= dsd_ff[DVD_W].force_full;
      end
   end

   // output search, one bit per step from the top
   always_comb begin
      for (int j = 0; j < V_W; j++) begin
         if (j == 0) begin
            st_in[j] = tgt_ff;
         end else begin
            st_in[j]   = st_out[j-1];
            st_in[j].v = v_dec[j-1];
         end
         st_in[j].cand     = st_in[j].v | (V_W'(1) << (OB - j));
         st_in[j].range_ok = st_in[j].cand <= (V_W'(1) << OB);
         x2_w[j]           = {st_in[j].cand, 1'b0} - (V_W+1)'(1);
         x_w[j]            = x2_w[j][V_W-1:0];
         v_dec[j] = (st_out[j].range_ok &&
                     ($signed({{(TGT_W-LOG_W){1'b0}}, lx[j]}) <=
                      $signed(st_out[j].target))) ? st_out[j].cand : st_out[j].v;
      end
   end

   for (genvar j = 0; j < V_W; j++) begin : g_step
      rtmp_log2 #(
         .XW (V_W),
         .SW ($bits(rtmp_pkg::srch_side_type))
      ) u_log_v (
         .clock    (clock),
         .reset    (reset),
         .x_in     (x_w[j]),
         .side_in  (st_in[j]),
         .log_out  (lx[j]),
         .side_out (st_out[j])
      );
   end

   // final clamp
   always_ff @(posedge clock) begin
      if (st_out[V_W-1].chan_zero) begin
         res_ff <= '0;
      end else if (st_out[V_W-1].force_full ||
                   v_dec[V_W-1] > V_W'(rtmp_pkg::FULL_SCALE)) begin
         res_ff <= rtmp_pkg::FULL_SCALE;
      end else begin
         res_ff <= v_dec[V_W-1][OB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= st_out[V_W-1].ctl;
      end
   end

   assign res_out = res_ff;
   assign ctl_out = ctl_ff;

endmodule

[hw/rtl/rational_tone_map_pixel_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_tone_map_pixel_top
// Schlick uniform rational tone mapping of one HDR RGB pixel per transaction.
// ----------------------------------------------------------------------------
// Fully pipelined: a new pixel may be started on every clock and busy is never
// raised. Each pixel yields one result on rsp_data, marked by rsp_strobe for a
// single cycle; the receiver cannot stall it. The pipeline depth comes mostly
// from the per-channel output search: 17 search steps, each a 23-stage log2
// squaring pipeline, behind a 39-stage gamma divider and the luminance and
// numerator front end. The user must write configuration only while no pixel
// is in flight; the block itself does not enforce it.
module rational_tone_map_pixel_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  rtmp_pkg::req_type                     req_data,
   output logic                                  rsp_strobe,
   output rtmp_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rtmp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rtmp_pkg::CSR_DATA_W-1:0]       csr_data
);
   localparam int NL = rtmp_pkg::NUM_LANES;
   localparam int CW = rtmp_pkg::CHAN_W;

   logic [rtmp_pkg::GAIN_W-1:0]  gain_ff;
   logic [rtmp_pkg::LMAX_W-1:0]  lmax_ff;
   logic [rtmp_pkg::SHAPE_W-1:0] shape_ff;
   logic [rtmp_pkg::GAMMA_W-1:0] gamma_ff;
   logic [rtmp_pkg::SHAPE_W-1:0] p_w;
   logic [rtmp_pkg::SHAPE_W-1:0] pm_w;
   logic [rtmp_pkg::GAMMA_W-1:0] g_w;

   logic                         v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                         lz4_ff, lz5_ff;
   rtmp_pkg::req_type            s1_ff;
   logic [CW-1:0]                c2_ff [0:NL-1];
   logic [CW-1:0]                c3_ff [0:NL-1];
   logic [rtmp_pkg::PROD_W-1:0]  pr_ff [0:NL-1];
   logic [rtmp_pkg::SUM_W-1:0]   sum_w;
   logic [rtmp_pkg::LUM_W-1:0]   lum_ff;
   logic [rtmp_pkg::PD_W-1:0]    pd_ff;
   logic [rtmp_pkg::N_W-1:0]     n4_ff [0:NL-1];
   logic [rtmp_pkg::N_W-1:0]     n5_ff [0:NL-1];
   logic [rtmp_pkg::D_W-1:0]     d_ff;

   rtmp_pkg::lane_ctl_type       dctl_in;
   rtmp_pkg::lane_ctl_type       dctl_out;
   logic [rtmp_pkg::LOG_W-1:0]   ld;
   logic [rtmp_pkg::OUT_BITS-1:0] res_w [0:NL-1];
   rtmp_pkg::lane_ctl_type       lctl_w [0:NL-1];

   rtmp_pkg::rsp_type            rsp_ff;
   logic                         strobe_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= rtmp_pkg::GAIN_RESET;
         lmax_ff  <= rtmp_pkg::LMAX_RESET;
         shape_ff <= rtmp_pkg::SHAPE_RESET;
         gamma_ff <= rtmp_pkg::GAMMA_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rtmp_pkg::CSR_EXPOSURE: gain_ff  <= csr_data[rtmp_pkg::GAIN_W-1:0];
            rtmp_pkg::CSR_MAX_LUM:  lmax_ff  <= csr_data[rtmp_pkg::LMAX_W-1:0];
            rtmp_pkg::CSR_SHAPE:    shape_ff <= csr_data[rtmp_pkg::SHAPE_W-1:0];
            rtmp_pkg::CSR_GAMMA:    gamma_ff <= csr_data[rtmp_pkg::GAMMA_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // shape floor and gamma floor
   assign p_w  = (shape_ff < rtmp_pkg::SHAPE_ONE) ? rtmp_pkg::SHAPE_ONE : shape_ff;
   assign pm_w = p_w - rtmp_pkg::SHAPE_ONE;
   assign g_w  = (gamma_ff == '0) ? rtmp_pkg::GAMMA_W'(1) : gamma_ff;

   // valid pipeline of the front end
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   assign sum_w = rtmp_pkg::SUM_W'(pr_ff[0]) + rtmp_pkg::SUM_W'(pr_ff[1])
                + rtmp_pkg::SUM_W'(pr_ff[2]) + rtmp_pkg::SUM_W'(32768);

   // luminance, numerators and denominator
   always_ff @(posedge clock) begin
      s1_ff <= req_data;
      c2_ff[0] <= s1_ff.red_in;
      c2_ff[1] <= s1_ff.green_in;
      c2_ff[2] <= s1_ff.blue_in;
      pr_ff[0] <= rtmp_pkg::PROD_W'(s1_ff.red_in)   * rtmp_pkg::PROD_W'(rtmp_pkg::W_RED);
      pr_ff[1] <= rtmp_pkg::PROD_W'(s1_ff.green_in) * rtmp_pkg::PROD_W'(rtmp_pkg::W_GREEN);
      pr_ff[2] <= rtmp_pkg::PROD_W'(s1_ff.blue_in)  * rtmp_pkg::PROD_W'(rtmp_pkg::W_BLUE);
      lum_ff   <= sum_w[rtmp_pkg::SUM_W-1:16];
      pd_ff    <= rtmp_pkg::PD_W'(pm_w) * rtmp_pkg::PD_W'(lum_ff);
      lz4_ff   <= (lum_ff == '0) || (gain_ff == '0);
      lz5_ff   <= lz4_ff;
      d_ff     <= rtmp_pkg::D_W'(pd_ff) + rtmp_pkg::D_W'({lmax_ff, 8'b0});
      for (int k = 0; k < NL; k++) begin
         c3_ff[k] <= c2_ff[k];
         n4_ff[k] <= rtmp_pkg::N_W'(c3_ff[k]) * rtmp_pkg::N_W'(p_w);
         n5_ff[k] <= n4_ff[k];
      end
   end

   // log of the shared denominator
   assign dctl_in.valid    = v5_ff;
   assign dctl_in.lum_zero = lz5_ff;
   assign dctl_in.den_zero = (d_ff == '0);

   rtmp_log2 #(
      .XW (rtmp_pkg::D_W),
      .SW ($bits(rtmp_pkg::lane_ctl_type))
   ) u_log_d (
      .clock    (clock),
      .reset    (reset),
      .x_in     (d_ff),
      .side_in  (dctl_in),
      .log_out  (ld),
      .side_out (dctl_out)
   );

   // one lane per color channel
   for (genvar k = 0; k < NL; k++) begin : g_lane
      rtmp_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .n_in     (n5_ff[k]),
         .ld_in    (ld),
         .ctl_in   (dctl_out),
         .gamma_in (g_w),
         .res_out  (res_w[k]),
         .ctl_out  (lctl_w[k])
      );
   end

   // merge lanes, black on zero luminance or zero exposure gain
   always_ff @(posedge clock) begin
      if (lctl_w[0].lum_zero) begin
         rsp_ff <= '0;
      end else begin
         rsp_ff.red_out   <= res_w[0];
         rsp_ff.green_out <= res_w[1];
         rsp_ff.blue_out  <= res_w[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= lctl_w[0].valid;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[dv/rational_tone_map_pixel_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_tone_map_pixel_top_tb
// Self-checking bench for the Schlick rational tone map pipeline. A directed
// table and random pixels run under several register settings and idle
// patterns; every strobed result is compared against a bit-exact model or a pinned expectation.
// ----------------------------------------------------------------------------
module rational_tone_map_pixel_top_tb;

   localparam int CLK_HALF   = 2;
   localparam int LATENCY    = 462;
   localparam int STALL_LIMIT = 4000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   rtmp_pkg::req_type req_data = '0;
   logic    rsp_strobe;
   rtmp_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [rtmp_pkg::CSR_IDX_W-1:0]  csr_index = rtmp_pkg::CSR_EXPOSURE;
   logic [rtmp_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   // pinned expectation travels with the pixel
   logic    pin_valid = 1'b0;
   rtmp_pkg::rsp_type pin_value = '0;

   // mirror of the block's registers
   logic [rtmp_pkg::GAIN_W-1:0]  mir_gain;
   logic [rtmp_pkg::LMAX_W-1:0]  mir_lmax;
   logic [rtmp_pkg::SHAPE_W-1:0] mir_shape;
   logic [rtmp_pkg::GAMMA_W-1:0] mir_gamma;

   rtmp_pkg::rsp_type pending_pixels[$];
   int      errors = 0;
   int      quiet_cycles = 0;

   rational_tone_map_pixel_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // log2 in Q.20 by repeated squaring
   function automatic longint unsigned log2_q20(input longint unsigned x);
      int m;
      longint unsigned z;
      longint unsigned f;
      f = 0;
      if (x == 0) return 0;
      m = 63;
      while (x[m] == 1'b0) m--;
      z = (m >= 31) ? (x >> (m - 31)) : (x << (31 - m));
      for (int i = 0; i < rtmp_pkg::LOG_FRAC; i++) begin
         z = (z * z) >> 31;
         f = f << 1;
         if ((z >> 32) != 0) begin
            f = f | 1;
            z = z >> 1;
         end
      end
      return (longint'(m) << rtmp_pkg::LOG_FRAC) | f;
   endfunction

   // ratio raised to 1/gamma, rounded to output bits
   function automatic logic [rtmp_pkg::OUT_BITS-1:0] shade_channel(
         input longint unsigned c, input longint unsigned p,
         input longint unsigned den, input longint unsigned g);
      longint unsigned n, ln, ld, q, v, cand;
      longint target;
      v = 0;
      if (c == 0) return '0;
      if (den == 0) return rtmp_pkg::FULL_SCALE;
      n  = c * p;
      ln = log2_q20(n);
      ld = log2_q20(den);
      if (ln >= ld) return rtmp_pkg::FULL_SCALE;
      q = ((ld - ln) * 4096 + g / 2) / g;
      target = (longint'(rtmp_pkg::OUT_BITS + 1) << rtmp_pkg::LOG_FRAC) - longint'(q);
      for (int b = rtmp_pkg::OUT_BITS; b >= 0; b--) begin
         cand = v | (64'd1 << b);
         if (cand <= (64'd1 << rtmp_pkg::OUT_BITS) &&
             longint'(log2_q20(2 * cand - 1)) <= target)
            v = cand;
      end
      return (v > rtmp_pkg::FULL_SCALE) ? rtmp_pkg::FULL_SCALE
                                        : v[rtmp_pkg::OUT_BITS-1:0];
   endfunction

   function automatic rtmp_pkg::rsp_type tone_map(input rtmp_pkg::req_type px);
      longint unsigned lum, p, den, g;
      rtmp_pkg::rsp_type r;
      lum = (64'(rtmp_pkg::W_RED) * px.red_in + 64'(rtmp_pkg::W_GREEN) * px.green_in
             + 64'(rtmp_pkg::W_BLUE) * px.blue_in + 32768) >> 16;
      r = '0;
      if (lum == 0 || mir_gain == 0) return r;
      p   = (mir_shape < rtmp_pkg::SHAPE_ONE) ? 64'(rtmp_pkg::SHAPE_ONE) : 64'(mir_shape);
      den = (p - 256) * lum + 256 * 64'(mir_lmax);
      g   = (mir_gamma == 0) ? 1 : 64'(mir_gamma);
      r.red_out   = shade_channel(px.red_in, p, den, g);
      r.green_out = shade_channel(px.green_in, p, den, g);
      r.blue_out  = shade_channel(px.blue_in, p, den, g);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      errors++;
   endtask

   // monitor: register mirror, expected pixels, result check, watchdog
   always @(posedge clock) begin
      rtmp_pkg::rsp_type want;
      logic active;
      if (reset) begin
         mir_gain  <= rtmp_pkg::GAIN_RESET;
         mir_lmax  <= rtmp_pkg::LMAX_RESET;
         mir_shape <= rtmp_pkg::SHAPE_RESET;
         mir_gamma <= rtmp_pkg::GAMMA_RESET;
      end else begin
         active = 1'b0;
         if (csr_valid && csr_ready) begin
            active = 1'b1;
            case (csr_index)
               rtmp_pkg::CSR_EXPOSURE: mir_gain  <= csr_data[rtmp_pkg::GAIN_W-1:0];
               rtmp_pkg::CSR_MAX_LUM:  mir_lmax  <= csr_data[rtmp_pkg::LMAX_W-1:0];
               rtmp_pkg::CSR_SHAPE:    mir_shape <= csr_data[rtmp_pkg::SHAPE_W-1:0];
               rtmp_pkg::CSR_GAMMA:    mir_gamma <= csr_data[rtmp_pkg::GAMMA_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            active = 1'b1;
            pending_pixels.push_back(pin_valid ? pin_value : tone_map(req_data));
         end
         if (rsp_strobe) begin
            active = 1'b1;
            if (pending_pixels.size() == 0) begin
               report_mismatch("rsp_strobe", 1, 0);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_data.red_out != want.red_out)
                  report_mismatch("red_out", rsp_data.red_out, want.red_out);
               if (rsp_data.green_out != want.green_out)
                  report_mismatch("green_out", rsp_data.green_out, want.green_out);
               if (rsp_data.blue_out != want.blue_out)
                  report_mismatch("blue_out", rsp_data.blue_out, want.blue_out);
            end
         end
         quiet_cycles <= active ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("rational_tone_map_pixel_top test failed");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rtmp_pkg::CSR_IDX_W-1:0] idx,
         input logic [rtmp_pkg::CSR_DATA_W-1:0] val);
      logic took;
      wait_drained();
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      csr_valid <= 1'b0;
   endtask

   task automatic load_setting(input logic [31:0] gain, input logic [31:0] lmax,
         input logic [31:0] shape, input logic [31:0] gamma);
      write_reg(rtmp_pkg::CSR_EXPOSURE, gain);
      write_reg(rtmp_pkg::CSR_MAX_LUM, lmax);
      write_reg(rtmp_pkg::CSR_SHAPE, shape);
      write_reg(rtmp_pkg::CSR_GAMMA, gamma);
   endtask

   // one pixel transaction, with random idle cycles ahead of it
   task automatic send_pixel(input rtmp_pkg::req_type px, input logic pin,
         input rtmp_pkg::rsp_type want, input int idle_pct);
      logic took;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_data  <= px;
      pin_valid <= pin;
      pin_value <= want;
      do begin
         @(negedge clock);
         took = !busy;
         @(posedge clock);
      end while (!took);
   endtask

   function automatic logic [31:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return $urandom;
         2: return 32'hFFFF_FFFF;
         3: return $urandom_range(0, 3);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic random_pixels(input int count, input int idle_pct, input logic pause);
      rtmp_pkg::req_type px;
      for (int i = 0; i < count; i++) begin
         px.red_in   = rand_chan();
         px.green_in = rand_chan();
         px.blue_in  = rand_chan();
         send_pixel(px, 1'b0, '0, idle_pct);
         // hold off until the pipeline is empty
         if (pause && i == count / 2) begin
            start <= 1'b0;
            @(posedge clock);
            wait_drained();
         end
      end
      start <= 1'b0;
   endtask

   typedef struct {
      rtmp_pkg::req_type px;
      logic              pin;
      rtmp_pkg::rsp_type want;
   } pixel_row_type;

   pixel_row_type directed_rows[$];
   int            idle_mix[3] = '{0, 56, 18};

   initial begin
      directed_rows = '{
         '{'{32'h0, 32'h0, 32'h0}, 1'b1, '{16'h0, 16'h0, 16'h0}},
         '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
           '{rtmp_pkg::FULL_SCALE, rtmp_pkg::FULL_SCALE, rtmp_pkg::FULL_SCALE}},
         '{'{32'h1, 32'h0, 32'h0}, 1'b1, '{16'h0, 16'h0, 16'h0}},
         '{'{32'h0, 32'h1, 32'h0}, 1'b0, '0},
         '{'{32'h0, 32'h0001_0000, 32'h0}, 1'b0, '0},
         '{'{32'h0001_0000, 32'h0001_0000, 32'h0001_0000}, 1'b0, '0},
         '{'{32'h8000_0000, 32'h0, 32'h0}, 1'b0, '0},
         '{'{32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b0, '0},
         '{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0},
         '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '0},
         '{'{32'h0000_0100, 32'h0000_8000, 32'h0002_0000}, 1'b0, '0},
         '{'{32'h00FF_0000, 32'h0000_00FF, 32'h0}, 1'b0, '0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset settings
      foreach (directed_rows[i])
         send_pixel(directed_rows[i].px, directed_rows[i].pin, directed_rows[i].want, 0);
      start <= 1'b0;

      // zero exposure
      load_setting(32'd0, 32'd65536, 32'd512, 32'd9011);
      random_pixels(20, 0, 1'b0);
      // zero denominator
      load_setting(32'd256, 32'd0, 32'd256, 32'd9011);
      random_pixels(40, 56, 1'b0);
      // extremes, shape below one, smallest gamma
      load_setting(32'd65535, 32'hFFFF_FFFF, 32'd0, 32'd1);
      random_pixels(100, 18, 1'b0);
      // wide writes: masked shape, gamma masked to zero
      load_setting(32'hFFFF_0100, 32'd1, 32'hFFFF_FF00, 32'h0001_0000);
      random_pixels(100, 0, 1'b0);
      load_setting(32'd256, 32'd65536, 32'd5120, 32'd40960);
      random_pixels(100, 56, 1'b0);
      load_setting(32'd128, 32'h0100_0000, 32'd8191, 32'd65535);
      random_pixels(100, 0, 1'b1);
      for (int k = 0; k < 8; k++) begin
         load_setting($urandom_range(0, 15) == 0 ? 32'd0 : $urandom,
                      $urandom >> $urandom_range(0, 31),
                      $urandom_range(0, 8191),
                      $urandom_range(0, 15) == 0 ? 32'd0 : $urandom_range(1, 65535));
         random_pixels(110, idle_mix[k % 3], k == 4);
      end

      wait_drained();
      repeat (LATENCY + 8) @(posedge clock);
      if (errors == 0 && pending_pixels.size() == 0)
         $display("rational_tone_map_pixel_top test passed");
      else
         $display("rational_tone_map_pixel_top test failed");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/rtmp_pkg.sv
hw/rtl/rtmp_log2.sv
hw/rtl/rtmp_lane.sv
hw/rtl/rational_tone_map_pixel_top.sv
dv/rational_tone_map_pixel_top_tb.sv
